FILE: hw/rtl/dbd_pkg.sv
package dbd_pkg;

	localparam int unsigned TimeW = 32;
	localparam int unsigned ConfW = 16;
	localparam int unsigned IvlW  = 16;
	localparam int unsigned AddrW = 5;
	localparam int unsigned DataW = 32;

	// register map, index = paddr / 4
	localparam logic [2:0] REG_MIN_INTERVAL = 3'd0;
	localparam logic [2:0] REG_MAX_INTERVAL = 3'd1;
	localparam logic [2:0] REG_WAIT_TIMEOUT = 3'd2;
	localparam logic [2:0] REG_REFRACTORY   = 3'd3;
	localparam logic [2:0] REG_EMIT_SINGLE  = 3'd4;

	localparam logic [IvlW-1:0] RST_MIN_INTERVAL = 16'd100;
	localparam logic [IvlW-1:0] RST_MAX_INTERVAL = 16'd600;
	localparam logic [IvlW-1:0] RST_WAIT_TIMEOUT = 16'd700;
	localparam logic [IvlW-1:0] RST_REFRACTORY   = 16'd500;
	localparam logic            RST_EMIT_SINGLE  = 1'b0;

	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_BLINK = 1'b1;

	localparam logic EV_SINGLE = 1'b0;
	localparam logic EV_DOUBLE = 1'b1;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_WAIT = 2'd1,
		MODE_REFR = 2'd2
	} mode_t;

	typedef struct packed {
		logic [IvlW-1:0] min_interval_ms;
		logic [IvlW-1:0] max_interval_ms;
		logic [IvlW-1:0] wait_timeout_ms;
		logic [IvlW-1:0] refractory_ms;
		logic            emit_single_on_timeout;
	} cfg_t;

	typedef struct packed {
		logic             event_kind;
		logic [TimeW-1:0] event_time_ms;
		logic [TimeW-1:0] first_blink_ms;
		logic [TimeW-1:0] second_blink_ms;
		logic             has_second;
		logic [IvlW-1:0]  gap_ms;
		logic             has_gap;
		logic [ConfW-1:0] event_confidence;
	} event_t;

endpackage

FILE: hw/rtl/dbd_apb_regs.sv
module dbd_apb_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dbd_pkg::AddrW-1:0]     paddr,
	input  logic [dbd_pkg::DataW-1:0]     pwdata,
	output logic [dbd_pkg::DataW-1:0]     prdata,
	output logic                          pready,
	output dbd_pkg::cfg_t                 cfg
);

	dbd_pkg::cfg_t cfg_q;
	logic [2:0]    reg_idx;
	logic          wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[dbd_pkg::AddrW-1:2];
	assign wr_en   = psel & penable & pwrite & pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_interval_ms        <= dbd_pkg::RST_MIN_INTERVAL;
			cfg_q.max_interval_ms        <= dbd_pkg::RST_MAX_INTERVAL;
			cfg_q.wait_timeout_ms        <= dbd_pkg::RST_WAIT_TIMEOUT;
			cfg_q.refractory_ms          <= dbd_pkg::RST_REFRACTORY;
			cfg_q.emit_single_on_timeout <= dbd_pkg::RST_EMIT_SINGLE;
		end else if (wr_en) begin
			case (reg_idx)
				dbd_pkg::REG_MIN_INTERVAL: begin
					cfg_q.min_interval_ms <= pwdata[dbd_pkg::IvlW-1:0];
				end
				dbd_pkg::REG_MAX_INTERVAL: begin
					cfg_q.max_interval_ms <= pwdata[dbd_pkg::IvlW-1:0];
				end
				dbd_pkg::REG_WAIT_TIMEOUT: begin
					cfg_q.wait_timeout_ms <= pwdata[dbd_pkg::IvlW-1:0];
				end
				dbd_pkg::REG_REFRACTORY: begin
					cfg_q.refractory_ms <= pwdata[dbd_pkg::IvlW-1:0];
				end
				dbd_pkg::REG_EMIT_SINGLE: begin
					cfg_q.emit_single_on_timeout <= pwdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			dbd_pkg::REG_MIN_INTERVAL: prdata = {16'd0, cfg_q.min_interval_ms};
			dbd_pkg::REG_MAX_INTERVAL: prdata = {16'd0, cfg_q.max_interval_ms};
			dbd_pkg::REG_WAIT_TIMEOUT: prdata = {16'd0, cfg_q.wait_timeout_ms};
			dbd_pkg::REG_REFRACTORY:   prdata = {16'd0, cfg_q.refractory_ms};
			dbd_pkg::REG_EMIT_SINGLE:  prdata = {31'd0, cfg_q.emit_single_on_timeout};
			default:                   prdata = '0;
		endcase
	end

endmodule

FILE: hw/rtl/dbd_engine.sv
module dbd_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  logic                          opcode,
	input  logic [dbd_pkg::TimeW-1:0]     time_ms,
	input  logic [dbd_pkg::ConfW-1:0]     blink_confidence,
	input  dbd_pkg::cfg_t                 cfg,
	output logic                          emit,
	output dbd_pkg::event_t               ev
);

	dbd_pkg::mode_t             mode_q, mode_n, mode_chk;
	logic [dbd_pkg::TimeW-1:0]  first_time_q, first_time_n;
	logic [dbd_pkg::ConfW-1:0]  first_conf_q, first_conf_n;
	logic [dbd_pkg::TimeW-1:0]  refr_end_q, refr_end_n;
	logic [dbd_pkg::TimeW-1:0]  since_first, since_refr;
	logic                       wait_expired, refr_done;
	logic [dbd_pkg::ConfW-1:0]  min_conf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= dbd_pkg::MODE_IDLE;
			first_time_q <= '0;
			first_conf_q <= '0;
			refr_end_q   <= '0;
		end else if (fire) begin
			mode_q       <= mode_n;
			first_time_q <= first_time_n;
			first_conf_q <= first_conf_n;
			refr_end_q   <= refr_end_n;
		end
	end

	assign since_first = time_ms - first_time_q;
	assign since_refr  = time_ms - refr_end_q;
	assign min_conf    = (first_conf_q < blink_confidence) ? first_conf_q : blink_confidence;

	always_comb begin
		wait_expired = (mode_q == dbd_pkg::MODE_WAIT) &&
			(since_first > {16'd0, cfg.wait_timeout_ms});
		// refractory is over once the end time is not in the future (sign of time minus end time)
		refr_done = (mode_q == dbd_pkg::MODE_REFR) && !since_refr[dbd_pkg::TimeW-1];

		case (mode_q)
			dbd_pkg::MODE_WAIT: mode_chk = wait_expired ? dbd_pkg::MODE_IDLE : dbd_pkg::MODE_WAIT;
			dbd_pkg::MODE_REFR: mode_chk = refr_done ? dbd_pkg::MODE_IDLE : dbd_pkg::MODE_REFR;
			default:            mode_chk = dbd_pkg::MODE_IDLE;
		endcase

		mode_n       = mode_chk;
		first_time_n = first_time_q;
		first_conf_n = wait_expired ? '0 : first_conf_q;
		refr_end_n   = refr_end_q;
		emit         = 1'b0;

		ev.event_kind       = dbd_pkg::EV_SINGLE;
		ev.event_time_ms    = time_ms;
		ev.first_blink_ms   = first_time_q;
		ev.second_blink_ms  = '0;
		ev.has_second       = 1'b0;
		ev.gap_ms           = '0;
		ev.has_gap          = 1'b0;
		ev.event_confidence = first_conf_q;

		if (opcode == dbd_pkg::OP_TICK) begin
			emit = wait_expired & cfg.emit_single_on_timeout;
		end else begin
			case (mode_chk)
				dbd_pkg::MODE_REFR: begin
				end
				dbd_pkg::MODE_WAIT: begin
					// too soon: drop the blink
					if (since_first < {16'd0, cfg.min_interval_ms}) begin
					end else if (since_first <= {16'd0, cfg.max_interval_ms}) begin
						emit                = 1'b1;
						ev.event_kind       = dbd_pkg::EV_DOUBLE;
						ev.second_blink_ms  = time_ms;
						ev.has_second       = 1'b1;
						ev.gap_ms           = since_first[dbd_pkg::IvlW-1:0];
						ev.has_gap          = 1'b1;
						ev.event_confidence = min_conf;
						mode_n              = dbd_pkg::MODE_REFR;
						refr_end_n          = time_ms + {16'd0, cfg.refractory_ms};
					end else begin
						// too late: restart the sequence from this blink
						first_time_n = time_ms;
						first_conf_n = blink_confidence;
					end
				end
				default: begin
					mode_n       = dbd_pkg::MODE_WAIT;
					first_time_n = time_ms;
					first_conf_n = blink_confidence;
				end
			endcase
		end
	end

endmodule

FILE: hw/rtl/double_blink_detector_core.sv
// Path: the input register takes an accepted beat, and the result register takes the event
// that the engine emits from it; the master side is driven from the result register.
// Throughput: one tick or blink beat per cycle; the input register advances
// whenever the result register is free or the item yields no event.
// Reset: arst_n asynchronous, active low; clears mode to idle, the stored
// timestamps and both valid flags, and loads the register defaults.
module double_blink_detector_core (
	input  logic                          clk,
	input  logic                          arst_n,
	// APB configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dbd_pkg::AddrW-1:0]     paddr,
	input  logic [dbd_pkg::DataW-1:0]     pwdata,
	output logic [dbd_pkg::DataW-1:0]     prdata,
	output logic                          pready,
	// input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [47:0]                   s_tdata,  // time_ms[31:0], blink_confidence[47:32]
	input  logic                          s_tuser,  // opcode
	// event stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// event_time_ms[31:0], first_blink_ms[63:32], second_blink_ms[95:64],
	// has_second[96], gap_ms[112:97], has_gap[113], event_confidence[129:114], zero pad
	output logic [135:0]                  m_tdata,
	output logic                          m_tuser   // event_kind
);

	dbd_pkg::cfg_t              cfg;
	dbd_pkg::event_t            ev, ev_s2;
	logic                       item_valid_s1, opcode_s1;
	logic [dbd_pkg::TimeW-1:0]  time_s1;
	logic [dbd_pkg::ConfW-1:0]  conf_s1;
	logic                       out_valid_s2;
	logic                       emit, fire, out_free;

	dbd_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dbd_engine u_engine (
		.clk              (clk),
		.arst_n           (arst_n),
		.fire             (fire),
		.opcode           (opcode_s1),
		.time_ms          (time_s1),
		.blink_confidence (conf_s1),
		.cfg              (cfg),
		.emit             (emit),
		.ev               (ev)
	);

	assign out_free = !out_valid_s2 || m_tready;
	assign fire     = item_valid_s1 && (out_free || !emit);
	assign s_tready = !item_valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			item_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			opcode_s1 <= s_tuser;
			time_s1   <= s_tdata[31:0];
			conf_s1   <= s_tdata[47:32];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (fire && emit) begin
			out_valid_s2 <= 1'b1;
		end else if (m_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	// hold the event while the master side stalls
	always_ff @(posedge clk) begin
		if (fire && emit) begin
			ev_s2 <= ev;
		end
	end

	assign m_tvalid = out_valid_s2;
	assign m_tuser  = ev_s2.event_kind;
	assign m_tdata  = {6'd0, ev_s2.event_confidence, ev_s2.has_gap, ev_s2.gap_ms,
		ev_s2.has_second, ev_s2.second_blink_ms, ev_s2.first_blink_ms,
		ev_s2.event_time_ms};

endmodule

FILE: hw/rtl/dbd_checker.sv
module dbd_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         pready,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [135:0] m_tdata,
	input  logic         m_tuser
);

	// a stalled beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("event beat changed while stalled");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

	a_single_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == dbd_pkg::EV_SINGLE |->
		m_tdata[95:64] == 32'd0 && !m_tdata[96] && m_tdata[112:97] == 16'd0 && !m_tdata[113])
		else $error("single event carries second blink data");

	a_double_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == dbd_pkg::EV_DOUBLE |->
		m_tdata[96] && m_tdata[113] && m_tdata[95:64] == m_tdata[31:0])
		else $error("double event flags or second blink time wrong");

	a_double_gap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == dbd_pkg::EV_DOUBLE |->
		m_tdata[63:32] + {16'd0, m_tdata[112:97]} == m_tdata[31:0])
		else $error("double event gap does not match its timestamps");

endmodule

bind double_blink_detector_core dbd_checker u_dbd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.pready   (pready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
